// ----- hdl/cdf_pkg.sv -----
`default_nettype none
package cdf_pkg;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CONV  = 8'b0000_0010,
    S_PRE   = 8'b0000_0100,
    S_SKIP  = 8'b0000_1000,
    S_INT   = 8'b0001_0000,
    S_SEP   = 8'b0010_0000,
    S_COMMA = 8'b0100_0000,
    S_CENT  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    CH_DIGIT,
    CH_R,
    CH_DOLLAR,
    CH_SPACE,
    CH_DOT,
    CH_COMMA
  } char_sel_t;

  localparam logic [7:0] ASCII_R      = 8'h52;
  localparam logic [7:0] ASCII_DOLLAR = 8'h24;
  localparam logic [7:0] ASCII_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_DOT    = 8'h2E;
  localparam logic [7:0] ASCII_COMMA  = 8'h2C;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  typedef struct packed {
    logic      load;
    logic      step;
    logic      shift;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hdl/cdf_datapath.sv -----
`default_nettype none
module cdf_datapath
  import cdf_pkg::*;
#(
  parameter int unsigned AMOUNT_BITS = 63
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [AMOUNT_BITS-1:0] amount,
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  localparam int unsigned NDIG = (AMOUNT_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W = NDIG * 4;

  logic [BCD_W-1:0]       bcd_r, bcd_nxt, bcd_adj;
  logic [AMOUNT_BITS-1:0] amt_r, amt_nxt;
  logic [3:0]             top;
  logic [7:0]             ch;
  logic                   out_valid_r;
  logic [7:0]             out_data_r;
  logic                   out_last_r;

  assign top = bcd_r[BCD_W-1 -: 4];

  // add-3 correction, each digit on its own
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    amt_nxt = amt_r;
    if (cmd.load) begin
      bcd_nxt = '0;
      amt_nxt = amount;
    end else if (cmd.step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], amt_r[AMOUNT_BITS-1]};
      amt_nxt = {amt_r[AMOUNT_BITS-2:0], 1'b0};
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_comb begin
    unique case (cmd.sel)
      CH_DIGIT:  ch = {ASCII_DIGIT_HI, top};
      CH_R:      ch = ASCII_R;
      CH_DOLLAR: ch = ASCII_DOLLAR;
      CH_SPACE:  ch = ASCII_SPACE;
      CH_DOT:    ch = ASCII_DOT;
      CH_COMMA:  ch = ASCII_COMMA;
      default:   ch = ASCII_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    amt_r <= amt_nxt;
    if (cmd.emit) begin
      out_data_r <= ch;
      out_last_r <= cmd.last;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.top_zero = (top == 4'd0);
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ----- hdl/cdf_ctrl.sv -----
`default_nettype none
module cdf_ctrl
  import cdf_pkg::*;
#(
  parameter int unsigned AMOUNT_BITS = 63
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam int unsigned NDIG  = (AMOUNT_BITS * 30103) / 100000 + 1;
  localparam int unsigned NINT  = NDIG - 2;
  localparam int unsigned NI_W  = $clog2(NINT + 1);
  localparam int unsigned CNT_W = $clog2(AMOUNT_BITS);
  localparam int unsigned G0    = (NINT - 1) % 3;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NI_W-1:0]  ni_r, ni_nxt;
  logic [1:0]       grp_r, grp_nxt, grp_dec;
  logic [1:0]       pc_r, pc_nxt;
  logic             adv;

  assign adv     = !sts.out_busy;
  assign grp_dec = (grp_r == 2'd0) ? 2'd2 : grp_r - 2'd1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ni_nxt    = ni_r;
    grp_nxt   = grp_r;
    pc_nxt    = pc_r;
    in_tready = 1'b0;
    cmd       = '{load: 1'b0, step: 1'b0, shift: 1'b0, emit: 1'b0,
                  sel: CH_DIGIT, last: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(AMOUNT_BITS - 1);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          pc_nxt    = 2'd0;
          ni_nxt    = NI_W'(NINT - 1);
          grp_nxt   = 2'(G0);
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        if (adv) begin
          cmd.emit = 1'b1;
          case (pc_r)
            2'd0:    cmd.sel = CH_R;
            2'd1:    cmd.sel = CH_DOLLAR;
            default: cmd.sel = CH_SPACE;
          endcase
          pc_nxt = pc_r + 2'd1;
          if (pc_r == 2'd2) begin
            state_nxt = S_SKIP;
          end
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one integer digit
        if (sts.top_zero && ni_r != '0) begin
          cmd.shift = 1'b1;
          ni_nxt    = ni_r - 1'b1;
          grp_nxt   = grp_dec;
        end else begin
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        if (adv) begin
          cmd.emit  = 1'b1;
          cmd.sel   = CH_DIGIT;
          cmd.shift = 1'b1;
          if (ni_r == '0) begin
            state_nxt = S_COMMA;
          end else begin
            ni_nxt  = ni_r - 1'b1;
            grp_nxt = grp_dec;
            if (grp_r == 2'd0) begin
              state_nxt = S_SEP;
            end
          end
        end
      end
      S_SEP: begin
        if (adv) begin
          cmd.emit  = 1'b1;
          cmd.sel   = CH_DOT;
          state_nxt = S_INT;
        end
      end
      S_COMMA: begin
        if (adv) begin
          cmd.emit  = 1'b1;
          cmd.sel   = CH_COMMA;
          pc_nxt    = 2'd0;
          state_nxt = S_CENT;
        end
      end
      S_CENT: begin
        if (adv) begin
          cmd.emit  = 1'b1;
          cmd.sel   = CH_DIGIT;
          cmd.shift = 1'b1;
          pc_nxt    = pc_r + 2'd1;
          if (pc_r != 2'd0) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ni_r  <= ni_nxt;
    grp_r <= grp_nxt;
    pc_r  <= pc_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/currency_decimal_formatter_core.sv -----
// Formats an amount in cents as "R$ " + integer digits grouped by '.' in threes + ',' + two
// cent digits, one ASCII character per output word, tlast on the final one. Zero gives
// "R$ 0,00". Only the low AMOUNT_BITS bits of the input are used. One amount is handled at
// a time: a double-dabble converter shifts in the amount bit by bit, the "R$ " prefix is
// sent, each leading zero of the integer field is dropped (at least one integer digit is
// kept), then the other characters leave at one per cycle while the output does not stall,
// through a single output register.
`default_nettype none
module currency_decimal_formatter_core
  import cdf_pkg::*;
#(
  parameter int unsigned AMOUNT_BITS = 63
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [62:0] amount_cents
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [7:0] text_char
  output logic                        out_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  cdf_ctrl #(
    .AMOUNT_BITS(AMOUNT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdf_datapath #(
    .AMOUNT_BITS(AMOUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .amount    (in_tdata[AMOUNT_BITS-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new amount taken during conversion");

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:4] == 4'h3 && out_tdata[3:0] <= 4'd9)
    else $error("final character is not a digit");

  a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("character emitted over a waiting word");

endmodule
`default_nettype wire

// ----- verif/currency_decimal_formatter_core_tb.sv -----
`default_nettype none
module currency_decimal_formatter_core_tb
  import cdf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned IDLE_PCT    = 13;
  localparam int unsigned RAND_AMOUNTS = 400;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_word_t;

  class amount_text_tracker;
    text_word_t pending_chars[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void push_char(logic [7:0] ch, logic last);
      text_word_t w;
      w.ch   = ch;
      w.last = last;
      pending_chars.push_back(w);
    endfunction

    // build the expected string for one accepted amount
    function void add_amount(logic [62:0] amt);
      longint unsigned whole;
      longint unsigned cents;
      logic [3:0]      digs[$];
      int              i;
      whole = 64'(amt) / 100;
      cents = 64'(amt) % 100;
      do begin
        digs.push_back(4'(whole % 10));
        whole = whole / 10;
      end while (whole != 0);
      push_char(ASCII_R, 1'b0);
      push_char(ASCII_DOLLAR, 1'b0);
      push_char(ASCII_SPACE, 1'b0);
      for (i = digs.size() - 1; i >= 0; i--) begin
        push_char({ASCII_DIGIT_HI, digs[i]}, 1'b0);
        if (i > 0 && (i % 3) == 0) begin
          push_char(ASCII_DOT, 1'b0);
        end
      end
      push_char(ASCII_COMMA, 1'b0);
      push_char({ASCII_DIGIT_HI, 4'(cents / 10)}, 1'b0);
      push_char({ASCII_DIGIT_HI, 4'(cents % 10)}, 1'b1);
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_word_t w;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual char %h last %b",
                 $time, ch, last);
        errors++;
        return;
      end
      w = pending_chars.pop_front();
      if (ch !== w.ch) begin
        $display("%0t: char mismatch: expected %h, actual %h", $time, w.ch, ch);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: tlast mismatch: expected %b, actual %b", $time, w.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [62:0] amount_cents
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] text_char
  logic                   out_tlast;

  logic                   calm;
  int unsigned            cycles;
  amount_text_tracker     tracker;

  currency_decimal_formatter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_char(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_amount(input logic [62:0] amt);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, amt};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    tracker.add_amount(amt);
  endtask

  function automatic logic [62:0] pick_amount();
    logic [63:0]     raw;
    longint unsigned pw;
    int unsigned     e;
    int unsigned     sel;
    raw = {$urandom, $urandom};
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      return raw[62:0];
    end else if (sel == 3) begin
      // near a digit times a power of ten, which includes where digit count and grouping change
      pw = 1;
      e  = $urandom_range(0, 18);
      repeat (e) pw = pw * 10;
      pw = pw * $urandom_range(1, 9) - $urandom_range(0, 1);
      return pw[62:0];
    end else begin
      return raw[62:0] & (63'h7FFF_FFFF_FFFF_FFFF >> (63 - $urandom_range(1, 63)));
    end
  endfunction

  initial begin
    logic [62:0] directed_amounts[$];
    int          k;
    tracker    = new();
    calm       = 1'b0;
    cycles     = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed_amounts = '{63'd0, 63'd1, 63'd5, 63'd9, 63'd10, 63'd99, 63'd100, 63'd101,
                         63'd999, 63'd1000, 63'd99999, 63'd100000, 63'd123456,
                         63'd99999999, 63'd100000000, 63'd100000000000,
                         63'd123456789012345678, 63'h4000_0000_0000_0000,
                         63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
                         63'h7FFF_FFFF_FFFF_FFFF};
    foreach (directed_amounts[i]) send_amount(directed_amounts[i]);

    for (k = 0; k < RAND_AMOUNTS; k++) begin
      calm = (k >= 150 && k < 250);
      send_amount(pick_amount());
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/cdf_pkg.sv
hdl/cdf_datapath.sv
hdl/cdf_ctrl.sv
hdl/currency_decimal_formatter_core.sv
verif/currency_decimal_formatter_core_tb.sv
